// ===== hdl/pps_pkg.sv =====
// Package for the preemptive priority scheduler core.
// Holds field widths, event, outcome and action codes, sequencer and buffer command types and the record type.
// No dependencies.
package pps_pkg;

   localparam int ID_W    = 4;
   localparam int PRI_W   = 8;
   localparam int BURST_W = 16;
   localparam int EL_W    = 16;
   localparam int OC_W    = 2;
   localparam int EV_W    = 3;
   localparam int STAMP_W = 32;

   localparam logic [EV_W-1:0] EV_PREEMPT  = 3'd0;
   localparam logic [EV_W-1:0] EV_YIELD    = 3'd1;
   localparam logic [EV_W-1:0] EV_BLOCK    = 3'd2;
   localparam logic [EV_W-1:0] EV_COMPLETE = 3'd3;
   localparam logic [EV_W-1:0] EV_START    = 3'd4;
   localparam logic [EV_W-1:0] EV_REJECT   = 3'd5;

   localparam logic [OC_W-1:0] OC_RAN   = 2'd0;
   localparam logic [OC_W-1:0] OC_YIELD = 2'd1;
   localparam logic [OC_W-1:0] OC_BLOCK = 2'd2;
   localparam logic [OC_W-1:0] OC_TERM  = 2'd3;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_CHECK,
      ST_SCAN,
      ST_TAKE,
      ST_EXEC,
      ST_REL,
      ST_PUSH,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      AFT_DISPATCH,
      AFT_PREEMPT,
      AFT_YIELD,
      AFT_START
   } after_type;

   typedef struct packed {
      logic [EV_W-1:0]    event_res;
      logic               from_valid;
      logic [ID_W-1:0]    from_task;
      logic               to_valid;
      logic [ID_W-1:0]    to_task;
      logic [STAMP_W-1:0] tick_stamp;
   } rec_type;

   typedef struct packed {
      logic push;
      logic flush;
   } buf_cmd_type;

endpackage

// ===== hdl/pps_if.sv =====
// Handshake channel interfaces for the scheduler request and response streams.
// Depends on pps_pkg.
interface pps_req_if;
   import pps_pkg::*;
   logic               valid;
   logic               ready;
   logic               action;
   logic [ID_W-1:0]    task_id;
   logic [PRI_W-1:0]   task_priority;
   logic [BURST_W-1:0] burst_ticks;
   logic [EL_W-1:0]    elapsed;
   logic [OC_W-1:0]    outcome;

   modport source (output valid, action, task_id, task_priority, burst_ticks, elapsed,
                   outcome, input ready);
   modport sink (input valid, action, task_id, task_priority, burst_ticks, elapsed,
                 outcome, output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;
   logic               valid;
   logic               ready;
   logic [EV_W-1:0]    event_res;
   logic               from_valid;
   logic [ID_W-1:0]    from_task;
   logic               to_valid;
   logic [ID_W-1:0]    to_task;
   logic [STAMP_W-1:0] tick_stamp;
   logic               last;

   modport source (output valid, event_res, from_valid, from_task, to_valid, to_task,
                   tick_stamp, last, input ready);
   modport sink (input valid, event_res, from_valid, from_task, to_valid, to_task,
                 tick_stamp, last, output ready);
endinterface

// ===== hdl/preemptive_priority_scheduler_core.sv =====
// Preemptive priority scheduler core: ready queue in RAM, scanned one entry per cycle.
// A tick walks the single RAM read port in each highest-priority scan and queue shift.
// One item is in work at a time; results leave through a holding stage and output register.
// Synchronous active-high reset empties the queue, idles the processor and zeroes the counter.
// Depends on pps_pkg, pps_if, pps_ram and pps_rsp_buf.
module preemptive_priority_scheduler_core #(
   parameter int MAX_TASKS     = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int BURST_BITS    = 16
) (
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req_chan,
   pps_rsp_if.source rsp_chan
);
   import pps_pkg::*;

   localparam int AW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int PB = PRIORITY_BITS;
   localparam int BB = BURST_BITS;
   localparam int EW = ID_W + PB + BB;

   state_type        state_ff, state_in, nxt_ff, nxt_in;
   after_type        after_ff, after_in;
   logic [CW-1:0]    idx_ff, idx_in, count_ff, count_in;
   logic             dv_ff, dv_in;
   logic [AW-1:0]    didx_ff, didx_in, bidx_ff, bidx_in;
   logic [EW-1:0]    best_ff, best_in, run_ff, run_in;
   logic             run_v_ff, run_v_in, pend_ff, pend_in;
   logic [STAMP_W-1:0] tick_ff, tick_in;
   logic [ID_W-1:0]  old_ff, old_in;
   rec_type          rec_ff, rec_in;

   logic               it_act_ff, it_act_in;
   logic [ID_W-1:0]    it_id_ff, it_id_in;
   logic [PRI_W-1:0]   it_pri_ff, it_pri_in;
   logic [BURST_W-1:0] it_burst_ff, it_burst_in;
   logic [EL_W-1:0]    it_el_ff, it_el_in;
   logic [OC_W-1:0]    it_oc_ff, it_oc_in;

   logic             we;
   logic [AW-1:0]    waddr, raddr;
   logic [EW-1:0]    wdata, rdata;
   buf_cmd_type      cmd;
   logic             buf_ok;

   logic [PB+PRI_W-1:0]   pri_wide;
   logic [BB+BURST_W-1:0] burst_wide;
   logic [EW-1:0]         new_entry;
   logic [BB+EL_W-1:0]    rb_wide, el_wide;
   logic [BB-1:0]         new_burst;
   logic [CW-1:0]         count_dec;

   assign pri_wide   = {{PB{1'b0}}, it_pri_ff};
   assign burst_wide = {{BB{1'b0}}, it_burst_ff};
   assign new_entry  = {it_id_ff, pri_wide[PB-1:0], burst_wide[BB-1:0]};
   assign rb_wide    = {{EL_W{1'b0}}, run_ff[BB-1:0]};
   assign el_wide    = {{BB{1'b0}}, it_el_ff};
   assign new_burst  = (rb_wide > el_wide) ? BB'(rb_wide - el_wide) : '0;
   assign count_dec  = count_ff - CW'(1);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      nxt_in      = nxt_ff;
      after_in    = after_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      dv_in       = 1'b0;
      didx_in     = didx_ff;
      bidx_in     = bidx_ff;
      best_in     = best_ff;
      run_in      = run_ff;
      run_v_in    = run_v_ff;
      pend_in     = pend_ff;
      tick_in     = tick_ff;
      old_in      = old_ff;
      rec_in      = rec_ff;
      it_act_in   = it_act_ff;
      it_id_in    = it_id_ff;
      it_pri_in   = it_pri_ff;
      it_burst_in = it_burst_ff;
      it_el_in    = it_el_ff;
      it_oc_in    = it_oc_ff;
      we          = 1'b0;
      waddr       = count_ff[AW-1:0];
      wdata       = new_entry;
      raddr       = idx_ff[AW-1:0];
      cmd         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               it_act_in   = req_chan.action;
               it_id_in    = req_chan.task_id;
               it_pri_in   = req_chan.task_priority;
               it_burst_in = req_chan.burst_ticks;
               it_el_in    = req_chan.elapsed;
               it_oc_in    = req_chan.outcome;
               if (req_chan.action == ACT_ADD) begin
                  state_in = ST_ADD;
               end else if (req_chan.elapsed != '0) begin
                  tick_in = tick_ff + STAMP_W'(1);
                  if (run_v_ff) begin
                     state_in = ST_CHECK;
                  end else if (count_ff != '0) begin
                     idx_in   = '0;
                     after_in = AFT_DISPATCH;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_ADD: begin
            if (count_ff == CW'(MAX_TASKS)) begin
               rec_in   = '{EV_REJECT, 1'b1, it_id_ff, 1'b0, '0, tick_ff};
               nxt_in   = ST_FIN;
               state_in = ST_PUSH;
            end else begin
               we       = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (count_ff != '0) begin
               idx_in   = '0;
               after_in = AFT_PREEMPT;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (dv_ff) begin
               if (didx_ff == '0 || rdata[BB +: PB] > best_ff[BB +: PB]) begin
                  best_in = rdata;
                  bidx_in = didx_ff;
               end
            end
            if (idx_ff < count_ff) begin
               dv_in   = 1'b1;
               didx_in = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end else if (!dv_ff) begin
               idx_in = CW'(bidx_ff) + CW'(1);
               if (after_ff == AFT_PREEMPT && !(best_ff[BB +: PB] > run_ff[BB +: PB])) begin
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_TAKE;
               end
            end
         end
         ST_TAKE: begin
            if (dv_ff) begin
               we    = 1'b1;
               waddr = didx_ff - AW'(1);
               wdata = rdata;
            end
            if (idx_ff < count_ff) begin
               dv_in   = 1'b1;
               didx_in = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end else if (!dv_ff) begin
               count_in = count_dec;
               run_in   = best_ff;
               run_v_in = 1'b1;
               pend_in  = 1'b1;
               case (after_ff)
                  AFT_DISPATCH: begin
                     state_in = ST_CHECK;
                  end
                  AFT_PREEMPT: begin
                     we       = 1'b1;
                     waddr    = count_dec[AW-1:0];
                     wdata    = run_ff;
                     count_in = count_ff;
                     rec_in   = '{EV_PREEMPT, 1'b1, run_ff[EW-1 -: ID_W], 1'b1,
                                  best_ff[EW-1 -: ID_W], tick_ff};
                     nxt_in   = ST_EXEC;
                     state_in = ST_PUSH;
                  end
                  AFT_YIELD: begin
                     rec_in   = '{EV_YIELD, 1'b1, old_ff, 1'b1, best_ff[EW-1 -: ID_W], tick_ff};
                     nxt_in   = ST_FIN;
                     state_in = ST_PUSH;
                  end
                  AFT_START: begin
                     rec_in   = '{EV_START, 1'b0, '0, 1'b1, best_ff[EW-1 -: ID_W], tick_ff};
                     nxt_in   = ST_FIN;
                     state_in = ST_PUSH;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            pend_in = 1'b0;
            if (pend_ff && it_oc_ff == OC_YIELD) begin
               run_v_in = 1'b0;
               old_in   = run_ff[EW-1 -: ID_W];
               if (count_ff != '0) begin
                  idx_in   = '0;
                  after_in = AFT_YIELD;
                  state_in = ST_SCAN;
               end else begin
                  rec_in   = '{EV_YIELD, 1'b1, run_ff[EW-1 -: ID_W], 1'b0, '0, tick_ff};
                  nxt_in   = ST_FIN;
                  state_in = ST_PUSH;
               end
            end else if (pend_ff && (it_oc_ff == OC_BLOCK || it_oc_ff == OC_TERM)) begin
               run_v_in = 1'b0;
               rec_in   = '{(it_oc_ff == OC_BLOCK) ? EV_BLOCK : EV_COMPLETE, 1'b1,
                            run_ff[EW-1 -: ID_W], 1'b0, '0, tick_ff};
               nxt_in   = ST_REL;
               state_in = ST_PUSH;
            end else begin
               run_in[BB-1:0] = new_burst;
               if (new_burst == '0) begin
                  run_v_in = 1'b0;
                  rec_in   = '{EV_COMPLETE, 1'b1, run_ff[EW-1 -: ID_W], 1'b0, '0, tick_ff};
                  nxt_in   = ST_REL;
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_REL: begin
            if (count_ff != '0) begin
               idx_in   = '0;
               after_in = AFT_START;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (buf_ok) begin
               state_in = nxt_ff;
            end
         end
         ST_FIN: begin
            cmd.flush = 1'b1;
            if (buf_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         run_v_ff <= 1'b0;
         run_ff   <= '0;
         pend_ff  <= 1'b0;
         tick_ff  <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         run_v_ff <= run_v_in;
         run_ff   <= run_in;
         pend_ff  <= pend_in;
         tick_ff  <= tick_in;
         dv_ff    <= dv_in;
      end
      nxt_ff      <= nxt_in;
      after_ff    <= after_in;
      idx_ff      <= idx_in;
      didx_ff     <= didx_in;
      bidx_ff     <= bidx_in;
      best_ff     <= best_in;
      old_ff      <= old_in;
      rec_ff      <= rec_in;
      it_act_ff   <= it_act_in;
      it_id_ff    <= it_id_in;
      it_pri_ff   <= it_pri_in;
      it_burst_ff <= it_burst_in;
      it_el_ff    <= it_el_in;
      it_oc_ff    <= it_oc_in;
   end

   pps_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_TASKS)
   ) u_queue (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   pps_rsp_buf u_rsp_buf (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .rec(rec_ff),
      .ok(buf_ok),
      .rsp_chan(rsp_chan)
   );
endmodule

// ===== hdl/pps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/pps_rsp_buf.sv =====
// Response buffer: holds the newest record until the next one or the end of the item
// decides its last flag, then moves it to the output register. Depends on pps_pkg, pps_if.
module pps_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  pps_pkg::buf_cmd_type  cmd,
   input  pps_pkg::rec_type      rec,
   output logic                  ok,
   pps_rsp_if.source             rsp_chan
);
   import pps_pkg::*;

   logic    hold_v_ff, hold_v_in;
   rec_type hold_ff, hold_in;
   logic    out_v_ff, out_v_in;
   rec_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    out_free;

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign ok = !hold_v_ff || out_free;

   always_comb begin
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      out_v_in    = out_v_ff && !rsp_chan.ready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      if (ok && (cmd.push || cmd.flush)) begin
         if (hold_v_ff) begin
            out_v_in    = 1'b1;
            out_in      = hold_ff;
            out_last_in = cmd.flush;
         end
         if (cmd.push) begin
            hold_in   = rec;
            hold_v_in = 1'b1;
         end else begin
            hold_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.event_res  = out_ff.event_res;
   assign rsp_chan.from_valid = out_ff.from_valid;
   assign rsp_chan.from_task  = out_ff.from_task;
   assign rsp_chan.to_valid   = out_ff.to_valid;
   assign rsp_chan.to_task    = out_ff.to_task;
   assign rsp_chan.tick_stamp = out_ff.tick_stamp;
   assign rsp_chan.last       = out_last_ff;
endmodule
